/* rtl/kvsrr_pkg.sv */
// ----------------------------------------------------------------------------
// kvsrr_pkg: shared types and constants of the key/value store
// Operation codes, field widths and the structs that travel along the chain.
// ----------------------------------------------------------------------------
package kvsrr_pkg;

    localparam int OP_W      = 3;
    localparam int KEY_W     = 16;
    localparam int VAL_W     = 16;
    localparam int ENTRY_W   = 7;
    localparam int ENTRY_MAX = 127;

    // default table size
    localparam int CAPACITY_DEFAULT = 64;

    // stream widths (data in whole bytes, op on the input user side)
    localparam int S_DATA_W = 48;
    localparam int S_USER_W = OP_W;
    localparam int M_DATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_PUT          = 3'd0,
        OP_GET          = 3'd1,
        OP_RANGE_REMOVE = 3'd2,
        OP_KEY_BY_VALUE = 3'd3,
        OP_CLEAR        = 3'd4
    } op_t;

    // operation token passed from cell to cell
    typedef struct packed {
        logic             valid;
        op_t              op;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
        logic [VAL_W-1:0] range_end;
        logic             hit;        // key or value matched in an earlier cell
        logic             have_free;  // a free slot was seen in an earlier cell
        logic [VAL_W-1:0] found_value;
        logic [KEY_W-1:0] found_key;
    } tok_t;

    // insert broadcast into the slot picked by a put
    typedef struct packed {
        logic             en;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } wr_t;

endpackage

/* rtl/kvsrr_cell.sv */
// ----------------------------------------------------------------------------
// kvsrr_cell: one slot of the key/value table
// Holds valid/key/value, applies the passing token and forwards it.
// ----------------------------------------------------------------------------
module kvsrr_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  kvsrr_pkg::tok_t       tok_in,
    input  logic [CNT_W-1:0]      cnt_in,
    input  logic [IDX_W-1:0]      free_in,
    input  kvsrr_pkg::wr_t        wr,
    input  logic [IDX_W-1:0]      wr_idx,
    output kvsrr_pkg::tok_t       tok_out,
    output logic [CNT_W-1:0]      cnt_out,
    output logic [IDX_W-1:0]      free_out
);

    logic                        slot_valid_reg, slot_valid_next;
    logic [kvsrr_pkg::KEY_W-1:0] slot_key_reg, slot_key_next;
    logic [kvsrr_pkg::VAL_W-1:0] slot_value_reg, slot_value_next;

    kvsrr_pkg::tok_t             tok_reg, tok_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [IDX_W-1:0]            free_reg, free_next;

    logic key_hit;
    logic val_eq;
    logic in_range;

    assign key_hit  = slot_valid_reg && (slot_key_reg == tok_in.key);
    assign val_eq   = slot_valid_reg && (slot_value_reg == tok_in.value);
    assign in_range = slot_valid_reg && (slot_value_reg >= tok_in.value)
                      && (slot_value_reg <= tok_in.range_end);

    always_comb
    begin
        tok_next        = tok_in;
        free_next       = free_in;
        slot_valid_next = slot_valid_reg;
        slot_key_next   = slot_key_reg;
        slot_value_next = slot_value_reg;

        if (tok_in.valid)
        begin
            case (tok_in.op)
                kvsrr_pkg::OP_PUT:
                begin
                    if (key_hit && !tok_in.hit)
                    begin
                        slot_value_next = tok_in.value;
                        tok_next.hit    = 1'b1;
                    end
                    if (!slot_valid_reg && !tok_in.have_free)
                    begin
                        tok_next.have_free = 1'b1;
                        free_next          = IDX_W'(INDEX);
                    end
                end
                kvsrr_pkg::OP_GET:
                begin
                    if (key_hit && !tok_in.hit)
                    begin
                        tok_next.hit         = 1'b1;
                        tok_next.found_value = slot_value_reg;
                    end
                end
                kvsrr_pkg::OP_RANGE_REMOVE:
                begin
                    if (in_range)
                        slot_valid_next = 1'b0;
                end
                kvsrr_pkg::OP_KEY_BY_VALUE:
                begin
                    if (val_eq && !tok_in.hit)
                    begin
                        tok_next.hit       = 1'b1;
                        tok_next.found_key = slot_key_reg;
                    end
                end
                kvsrr_pkg::OP_CLEAR:
                begin
                    slot_valid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end

        // insert from the end of the chain; never coincides with a token here
        if (wr.en && (wr_idx == IDX_W'(INDEX)))
        begin
            slot_valid_next = 1'b1;
            slot_key_next   = wr.key;
            slot_value_next = wr.value;
        end

        cnt_next = cnt_in + CNT_W'(slot_valid_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= 1'b0;
            tok_reg        <= '0;
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            tok_reg        <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_key_reg   <= slot_key_next;
        slot_value_reg <= slot_value_next;
        cnt_reg        <= cnt_next;
        free_reg       <= free_next;
    end

    assign tok_out  = tok_reg;
    assign cnt_out  = cnt_reg;
    assign free_out = free_reg;

endmodule

/* rtl/key_value_store_with_range_remove.sv */
// ----------------------------------------------------------------------------
// key_value_store_with_range_remove: fixed-capacity key/value table
// Chain of slot cells; one operation token walks the chain per transaction.
// ----------------------------------------------------------------------------
// Each accepted transaction carries one operation (put, get, range remove,
// key by value, clear) and yields exactly one result transaction. The table
// is a row of CAPACITY cells, each holding one slot. The operation travels as
// a token through the row, one cell per clock, so every slot is visited once
// in slot order: lookups keep the lowest-slot match, a put remembers the
// lowest free slot, and each cell adds its valid bit to a running entry count.
// After the last cell the token lands in a finish stage that, for a put of a
// new key, broadcasts the insert into the remembered slot and loads the
// output register. One operation is in flight at a time: a new transaction
// is not accepted before the last one has left the finish stage, and the
// next may be accepted in the same cycle that the result is first
// presented, while the result still waits in the output register. No
// clearing pass is needed after reset; slot valid bits reset directly.
module key_value_store_with_range_remove #(
    parameter int CAPACITY = kvsrr_pkg::CAPACITY_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [15:0] key, [31:16] value, [47:32] range_end
    input  logic [kvsrr_pkg::S_DATA_W-1:0]   s_tdata,
    // [2:0] op
    input  logic [kvsrr_pkg::S_USER_W-1:0]   s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] ok, [16:1] found_value, [32:17] found_key, [39:33] entry_total
    output logic [kvsrr_pkg::M_DATA_W-1:0]   m_tdata
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SAT_W = (CNT_W > kvsrr_pkg::ENTRY_W) ? CNT_W : kvsrr_pkg::ENTRY_W;

    // token, running count and free-slot index between cells
    kvsrr_pkg::tok_t  tok  [0:CAPACITY];
    logic [CNT_W-1:0] cnt  [0:CAPACITY];
    logic [IDX_W-1:0] free [0:CAPACITY];

    kvsrr_pkg::tok_t  tok_head;

    kvsrr_pkg::wr_t   wr;
    logic [IDX_W-1:0] wr_idx;

    logic accept;
    logic busy_reg, busy_next;

    // finish stage: holds the token that left the last cell
    logic             fin_valid_reg, fin_valid_next;
    kvsrr_pkg::tok_t  fin_tok_reg;
    logic [CNT_W-1:0] fin_cnt_reg;
    logic [IDX_W-1:0] fin_free_reg;

    logic finish;
    logic insert;
    logic res_ok;
    logic [SAT_W-1:0]                total_wide;
    logic [kvsrr_pkg::ENTRY_W-1:0]   total_sat;

    // output register
    logic                          m_valid_reg, m_valid_next;
    logic                          out_ok_reg;
    logic [kvsrr_pkg::VAL_W-1:0]   out_fval_reg;
    logic [kvsrr_pkg::KEY_W-1:0]   out_fkey_reg;
    logic [kvsrr_pkg::ENTRY_W-1:0] out_total_reg;

    logic [CAPACITY:0] in_flight;

    assign s_tready = !busy_reg;
    assign accept   = s_tvalid && s_tready;

    // token entering the first cell straight from the input transaction
    always_comb
    begin
        tok_head             = '0;
        tok_head.valid       = accept;
        tok_head.op          = kvsrr_pkg::op_t'(s_tuser);
        tok_head.key         = s_tdata[15:0];
        tok_head.value       = s_tdata[31:16];
        tok_head.range_end   = s_tdata[47:32];
    end
    assign tok[0]  = tok_head;
    assign cnt[0]  = '0;
    assign free[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            kvsrr_cell #(
                .INDEX (gi),
                .IDX_W (IDX_W),
                .CNT_W (CNT_W)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .tok_in   (tok[gi]),
                .cnt_in   (cnt[gi]),
                .free_in  (free[gi]),
                .wr       (wr),
                .wr_idx   (wr_idx),
                .tok_out  (tok[gi+1]),
                .cnt_out  (cnt[gi+1]),
                .free_out (free[gi+1])
            );
        end
    endgenerate

    always_comb
    begin
        in_flight[0] = fin_valid_reg;
        for (int i = 1; i <= CAPACITY; i++)
            in_flight[i] = tok[i].valid;
    end

    // finish when the output register is free or being emptied
    assign finish = fin_valid_reg && (!m_valid_reg || m_tready);
    assign insert = (fin_tok_reg.op == kvsrr_pkg::OP_PUT) && !fin_tok_reg.hit
                    && fin_tok_reg.have_free;

    assign wr.en    = finish && insert;
    assign wr.key   = fin_tok_reg.key;
    assign wr.value = fin_tok_reg.value;
    assign wr_idx   = fin_free_reg;

    always_comb
    begin
        case (fin_tok_reg.op)
            kvsrr_pkg::OP_PUT:          res_ok = fin_tok_reg.hit || fin_tok_reg.have_free;
            kvsrr_pkg::OP_GET:          res_ok = fin_tok_reg.hit;
            kvsrr_pkg::OP_RANGE_REMOVE: res_ok = 1'b1;
            kvsrr_pkg::OP_KEY_BY_VALUE: res_ok = fin_tok_reg.hit;
            kvsrr_pkg::OP_CLEAR:        res_ok = 1'b1;
            default:                    res_ok = 1'b0;
        endcase
    end

    // count saturates at the field maximum for large tables
    assign total_wide = SAT_W'(fin_cnt_reg) + SAT_W'(insert);
    assign total_sat  = (total_wide > SAT_W'(kvsrr_pkg::ENTRY_MAX))
                        ? kvsrr_pkg::ENTRY_W'(kvsrr_pkg::ENTRY_MAX)
                        : total_wide[kvsrr_pkg::ENTRY_W-1:0];

    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
            busy_next = 1'b1;
        else if (finish)
            busy_next = 1'b0;

        fin_valid_next = fin_valid_reg;
        if (tok[CAPACITY].valid)
            fin_valid_next = 1'b1;
        else if (finish)
            fin_valid_next = 1'b0;

        m_valid_next = m_valid_reg;
        if (finish)
            m_valid_next = 1'b1;
        else if (m_tready)
            m_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            fin_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            fin_valid_reg <= fin_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tok[CAPACITY].valid)
        begin
            fin_tok_reg  <= tok[CAPACITY];
            fin_cnt_reg  <= cnt[CAPACITY];
            fin_free_reg <= free[CAPACITY];
        end
        if (finish)
        begin
            out_ok_reg    <= res_ok;
            out_fval_reg  <= fin_tok_reg.found_value;
            out_fkey_reg  <= fin_tok_reg.found_key;
            out_total_reg <= total_sat;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {out_total_reg, out_fkey_reg, out_fval_reg, out_ok_reg};

    // at most one operation anywhere in the chain or finish stage
    a_single_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(in_flight))
        else $error("more than one operation in flight");

    // a token in the chain or finish stage implies the input is closed
    a_busy_cover: assert property (@(posedge clk) disable iff (!rst_n)
        (in_flight != '0) |-> busy_reg)
        else $error("operation in flight while input is open");

    // an insert only comes from a put that found no key and saw a free slot
    a_insert_put: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (fin_tok_reg.op == kvsrr_pkg::OP_PUT) && !fin_tok_reg.hit)
        else $error("insert from a non-put or a key already present");

    // the finish stage must drain before the next token arrives
    a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
        tok[CAPACITY].valid |-> !fin_valid_reg)
        else $error("token arrived at an occupied finish stage");

endmodule
